// ----- design/fcl_pkg.sv -----
// Shared types, widths and constants of the FOC current loop.
// Holds the sine table builder used by the trig reader; no dependencies.
package fcl_pkg;

   localparam int ENC_STEPS    = 16384;
   localparam int POLE_PAIRS   = 7;
   localparam int SINE_ENTRIES = 1024;

   localparam int ANG_W  = $clog2(ENC_STEPS);
   localparam int ROM_AW = $clog2(SINE_ENTRIES);
   localparam int FRAC_W = ANG_W - ROM_AW;

   localparam int MA_W  = 25;
   localparam int MB_W  = 18;
   localparam int ACC_W = 48;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [1:0] MAC_HOLD = 2'd0;
   localparam logic [1:0] MAC_LOAD = 2'd1;
   localparam logic [1:0] MAC_ADD  = 2'd2;
   localparam logic [1:0] MAC_SUB  = 2'd3;

   localparam logic [2:0] REG_OFFSET = 3'd0;
   localparam logic [2:0] REG_KP_D   = 3'd1;
   localparam logic [2:0] REG_KI_D   = 3'd2;
   localparam logic [2:0] REG_KP_Q   = 3'd3;
   localparam logic [2:0] REG_KI_Q   = 3'd4;
   localparam logic [2:0] REG_RATE   = 3'd5;
   localparam logic [2:0] REG_LIM_D  = 3'd6;
   localparam logic [2:0] REG_LIM_Q  = 3'd7;

   typedef struct packed {
      logic       en;
      logic [1:0] mode;
   } mac_ctl_type;

   typedef logic signed [15:0] rom_type [SINE_ENTRIES];

   function automatic logic signed [15:0] quarter_sine(input logic [63:0] r);
      logic [63:0]        t;
      logic [63:0]        t2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      t    = r * HALF_PI_Q30 / 64'(SINE_ENTRIES);
      t2   = (t * t) >> 30;
      sum  = $signed(t);
      term = ((t * t2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * t2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * t2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      if (v > 64'sd32767) begin
         v = 64'sd32767;
      end
      return 16'(v);
   endfunction

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] q4;
      logic [63:0] quad;
      logic [63:0] r;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         q4   = 64'(4 * k);
         quad = q4 / 64'(SINE_ENTRIES);
         r    = q4 % 64'(SINE_ENTRIES);
         case (quad)
            64'd0:   rom[k] = quarter_sine(r);
            64'd1:   rom[k] = quarter_sine(64'(SINE_ENTRIES) - r);
            64'd2:   rom[k] = -quarter_sine(r);
            default: rom[k] = -quarter_sine(64'(SINE_ENTRIES) - r);
         endcase
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

// ----- design/foc_current_loop_core.sv -----
// Top level of the FOC current loop: sequencer, state and config registers.
// Uses fcl_pkg, fcl_trig and fcl_mac.
//
//  channel | direction | handshake            | content
//  req     | in        | req_tvalid/tready    | position, phase currents, targets
//  rsp     | out       | rsp_tvalid/tready    | duties, d/q currents, averages
//  csr     | in        | csr_valid/csr_ready  | register index and value
//
// An item passes through the table reads of the trig reader, then 22 steps of
// the single multiply-accumulate unit, and the result loads the output
// register. req_tready is high only while the sequencer is idle.
// Reset is synchronous and clears control state and the loop state.
// A stalled result holds the final step until the output register is free.
module foc_current_loop_core import fcl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // rotor_position[31:0], phase_u_current[47:32], phase_v_current[63:48],
   // phase_w_current[79:64], target_d[95:80], target_q[111:96]
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // duty_u[15:0], duty_v[31:16], duty_w[47:32], current_d[63:48],
   // current_q[79:64], average_d[95:80], average_q[111:96]
   output logic [111:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TRIG = 2'd1;
   localparam logic [1:0] ST_MAC  = 2'd2;
   localparam logic [4:0] LAST_STEP = 5'd21;

   logic [1:0]  state_ff;
   logic [1:0]  state_in;
   logic [4:0]  step_ff;

   logic [13:0] offset_ff;
   logic [15:0] kp_d_ff, ki_d_ff, kp_q_ff, ki_q_ff;
   logic [2:0]  rate_ff;
   logic [14:0] lim_d_ff, lim_q_ff;

   logic signed [31:0] int_d_ff, int_q_ff, fd_ff, fq_ff;

   logic signed [17:0] s1_ff;
   logic signed [16:0] s2_ff;
   logic signed [15:0] td_ff, tq_ff;
   logic signed [16:0] ia_ff, ib_ff, ed_ff, eq_ff;
   logic signed [15:0] id_ff, iq_ff;
   logic signed [32:0] fdiff_ff;
   logic signed [21:0] cd_ff, cq_ff;
   logic signed [23:0] ca_ff, cb_ff, xv_ff, xw_ff;
   logic [15:0]        du_ff, dv_ff;

   logic               rsp_valid_ff;
   logic [111:0]       rsp_data_ff;

   logic               accept;
   logic               out_free;
   logic [ANG_W-1:0]   ang_diff;
   logic [ANG_W-1:0]   angle;
   logic               trig_done;
   logic signed [15:0] sine, cosine;

   mac_ctl_type             mac_ctl;
   logic signed [MA_W-1:0]  op_a;
   logic signed [MB_W-1:0]  op_b;
   logic signed [ACC_W-1:0] acc;
   logic signed [15:0]      sat_cur;
   logic [15:0]             duty_now;
   logic [23:0]             ki_d_sh, ki_q_sh;

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = x >>> 15;
      if (t > ACC_W'(32767)) begin
         return 16'sh7fff;
      end else if (t < -ACC_W'(32768)) begin
         return 16'sh8000;
      end
      return 16'(t);
   endfunction

   function automatic logic [15:0] duty_of(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = ACC_W'(32000) + (x >>> 15);
      if (t < 0) begin
         return 16'd0;
      end else if (t > ACC_W'(64000)) begin
         return 16'd64000;
      end
      return 16'(t);
   endfunction

   function automatic logic signed [31:0] integ(input logic signed [31:0] i,
                                                input logic signed [ACC_W-1:0] x,
                                                input logic [14:0] lim);
      logic signed [ACC_W-1:0] s;
      logic signed [ACC_W-1:0] l;
      s = ACC_W'(i) + x;
      l = $signed(ACC_W'({lim, 16'b0}));
      if (s > l) begin
         s = l;
      end else if (s < -l) begin
         s = -l;
      end
      return 32'(s);
   endfunction

   assign accept    = req_tvalid && req_tready;
   assign req_tready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign ang_diff  = req_tdata[ANG_W-1:0] - ANG_W'(offset_ff);
   assign angle     = ANG_W'(ang_diff * ANG_W'(POLE_PAIRS));
   assign sat_cur   = sat16(acc);
   assign duty_now  = duty_of(acc);
   assign ki_d_sh   = 24'({8'b0, ki_d_ff} << rate_ff);
   assign ki_q_sh   = 24'({8'b0, ki_q_ff} << rate_ff);

   fcl_trig u_trig (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .angle  (angle),
      .done   (trig_done),
      .sine   (sine),
      .cosine (cosine)
   );

   fcl_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   always_comb begin
      mac_ctl.en   = state_ff == ST_MAC && step_ff != LAST_STEP;
      mac_ctl.mode = MAC_LOAD;
      op_a         = '0;
      op_b         = '0;
      case (step_ff)
         5'd0:  begin op_a = MA_W'(s1_ff); op_b = 18'sd21845; end
         5'd1:  begin op_a = MA_W'(s2_ff); op_b = 18'sd37837; end
         5'd2:  begin op_a = MA_W'(ia_ff); op_b = MB_W'(cosine); end
         5'd3:  begin op_a = MA_W'(ib_ff); op_b = MB_W'(sine); mac_ctl.mode = MAC_ADD; end
         5'd4:  begin op_a = MA_W'(ib_ff); op_b = MB_W'(cosine); end
         5'd5:  begin op_a = MA_W'(ia_ff); op_b = MB_W'(sine); mac_ctl.mode = MAC_SUB; end
         5'd6:  begin op_a = $signed({1'b0, ki_d_sh}); op_b = MB_W'(ed_ff); end
         5'd7:  begin op_a = $signed({1'b0, ki_q_sh}); op_b = MB_W'(eq_ff); end
         5'd8:  begin op_a = $signed(MA_W'(kp_d_ff)); op_b = MB_W'(ed_ff); end
         5'd9:  begin op_a = $signed(MA_W'(kp_q_ff)); op_b = MB_W'(eq_ff); end
         5'd10: begin op_a = MA_W'(cd_ff); op_b = MB_W'(cosine); end
         5'd11: begin op_a = MA_W'(cq_ff); op_b = MB_W'(sine); mac_ctl.mode = MAC_SUB; end
         5'd12: begin op_a = MA_W'(cq_ff); op_b = MB_W'(cosine); end
         5'd13: begin op_a = MA_W'(cd_ff); op_b = MB_W'(sine); mac_ctl.mode = MAC_ADD; end
         5'd14: begin op_a = MA_W'(ca_ff); op_b = -18'sd32768; end
         5'd15: begin op_a = MA_W'(cb_ff); op_b = 18'sd56756; mac_ctl.mode = MAC_ADD; end
         5'd16: begin op_a = MA_W'(ca_ff); op_b = -18'sd32768; end
         5'd17: begin op_a = MA_W'(cb_ff); op_b = 18'sd56756; mac_ctl.mode = MAC_SUB; end
         5'd18: begin op_a = MA_W'(ca_ff); op_b = 18'sd32000; end
         5'd19: begin op_a = MA_W'(xv_ff); op_b = 18'sd32000; end
         5'd20: begin op_a = MA_W'(xw_ff); op_b = 18'sd32000; end
         default: mac_ctl.mode = MAC_HOLD;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_TRIG;
         ST_TRIG: if (trig_done) state_in = ST_MAC;
         ST_MAC:  if (step_ff == LAST_STEP && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= 18'($signed(req_tdata[47:32])) * 18'sd2 - 18'($signed(req_tdata[63:48]))
                  - 18'($signed(req_tdata[79:64]));
         s2_ff <= 17'($signed(req_tdata[63:48])) - 17'($signed(req_tdata[79:64]));
         td_ff <= $signed(req_tdata[95:80]);
         tq_ff <= $signed(req_tdata[111:96]);
      end
      if (state_ff == ST_MAC) begin
         case (step_ff)
            5'd1: ia_ff <= 17'(acc >>> 16);
            5'd2: ib_ff <= 17'(acc >>> 16);
            5'd4: begin
               id_ff <= sat_cur;
               ed_ff <= 17'(td_ff) - 17'(sat_cur);
            end
            5'd5: fdiff_ff <= 33'($signed({id_ff, 16'b0})) - 33'(fd_ff);
            5'd6: begin
               iq_ff <= sat_cur;
               eq_ff <= 17'(tq_ff) - 17'(sat_cur);
            end
            5'd7: fdiff_ff <= 33'($signed({iq_ff, 16'b0})) - 33'(fq_ff);
            5'd9:  cd_ff <= 22'(acc >>> 12) + 22'(int_d_ff >>> 16);
            5'd10: cq_ff <= 22'(acc >>> 12) + 22'(int_q_ff >>> 16);
            5'd12: ca_ff <= 24'(acc >>> 15);
            5'd14: cb_ff <= 24'(acc >>> 15);
            5'd16: xv_ff <= 24'(acc >>> 16);
            5'd18: xw_ff <= 24'(acc >>> 16);
            5'd19: du_ff <= duty_now;
            5'd20: dv_ff <= duty_now;
            default: ;
         endcase
      end
      if (state_ff == ST_MAC && step_ff == LAST_STEP && out_free) begin
         rsp_data_ff <= {fq_ff[31:16], fd_ff[31:16], iq_ff, id_ff, duty_now, dv_ff, du_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
         int_d_ff     <= '0;
         int_q_ff     <= '0;
         fd_ff        <= '0;
         fq_ff        <= '0;
         offset_ff    <= '0;
         kp_d_ff      <= '0;
         ki_d_ff      <= '0;
         kp_q_ff      <= '0;
         ki_q_ff      <= '0;
         rate_ff      <= '0;
         lim_d_ff     <= 15'h7fff;
         lim_q_ff     <= 15'h7fff;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MAC && step_ff != LAST_STEP) begin
            step_ff <= step_ff + 5'd1;
         end else if (state_ff != ST_MAC) begin
            step_ff <= 5'd0;
         end
         if (state_ff == ST_MAC && step_ff == LAST_STEP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MAC) begin
            case (step_ff)
               5'd6: fd_ff <= fd_ff + 32'(fdiff_ff >>> 10);
               5'd7: int_d_ff <= integ(int_d_ff, acc, lim_d_ff);
               5'd8: begin
                  int_q_ff <= integ(int_q_ff, acc, lim_q_ff);
                  fq_ff    <= fq_ff + 32'(fdiff_ff >>> 10);
               end
               default: ;
            endcase
         end
         if (csr_valid) begin
            case (csr_index)
               REG_OFFSET: offset_ff <= csr_data[13:0];
               REG_KP_D:   kp_d_ff   <= csr_data;
               REG_KI_D:   ki_d_ff   <= csr_data;
               REG_KP_Q:   kp_q_ff   <= csr_data;
               REG_KI_Q:   ki_q_ff   <= csr_data;
               REG_RATE:   rate_ff   <= csr_data[2:0];
               REG_LIM_D:  lim_d_ff  <= csr_data[14:0];
               REG_LIM_Q:  lim_q_ff  <= csr_data[14:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- design/fcl_trig.sv -----
// Sine and cosine of the electrical angle from the sine table with interpolation.
// Uses fcl_pkg; one table read per cycle.
module fcl_trig import fcl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANG_W-1:0]         angle,
   output logic                     done,
   output logic signed [15:0]       sine,
   output logic signed [15:0]       cosine
);

   logic [ANG_W-1:0]    ang_ff;
   logic                busy_ff;
   logic [2:0]          cnt_ff;
   logic                done_ff;
   logic signed [15:0]  q_ff;
   logic signed [15:0]  lo_ff;
   logic signed [15:0]  sin_ff;
   logic signed [15:0]  cos_ff;
   logic [ROM_AW-1:0]   idx_s;
   logic [ROM_AW-1:0]   idx_c;
   logic [ROM_AW-1:0]   addr;
   logic signed [15:0]  interp;

   function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                                input logic signed [15:0] b,
                                                input logic [FRAC_W-1:0] f);
      logic signed [16:0]        d;
      logic signed [FRAC_W+17:0] p;
      d = 17'(b) - 17'(a);
      p = (FRAC_W+18)'(d) * $signed({1'b0, f});
      if (p < 0) begin
         p = p + (FRAC_W+18)'((1 << FRAC_W) - 1);
      end
      return a + 16'(p >>> FRAC_W);
   endfunction

   assign idx_s  = ang_ff[ANG_W-1 -: ROM_AW];
   assign idx_c  = idx_s + ROM_AW'(SINE_ENTRIES / 4);
   assign interp = lerp(lo_ff, q_ff, ang_ff[FRAC_W-1:0]);

   always_comb begin
      case (cnt_ff)
         3'd0:    addr = idx_s;
         3'd1:    addr = idx_s + 1'b1;
         3'd2:    addr = idx_c;
         default: addr = idx_c + 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      q_ff <= SINE_ROM[addr];
      if (start) begin
         ang_ff <= angle;
      end
      if (busy_ff && (cnt_ff == 3'd1 || cnt_ff == 3'd3)) begin
         lo_ff <= q_ff;
      end
      if (busy_ff && cnt_ff == 3'd2) begin
         sin_ff <= interp;
      end
      if (busy_ff && cnt_ff == 3'd4) begin
         cos_ff <= interp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == 3'd4;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 3'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done   = done_ff;
   assign sine   = sin_ff;
   assign cosine = cos_ff;

endmodule

// ----- design/fcl_mac.sv -----
// Shared multiply-accumulate unit of the current loop.
// Uses fcl_pkg for widths and mode codes.
module fcl_mac import fcl_pkg::*; (
   input  logic                     clock,
   input  mac_ctl_type              ctl,
   input  logic signed [MA_W-1:0]   op_a,
   input  logic signed [MB_W-1:0]   op_b,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] prod;

   assign prod = ACC_W'(op_a) * ACC_W'(op_b);

   always_comb begin
      case (ctl.mode)
         MAC_LOAD: acc_in = prod;
         MAC_ADD:  acc_in = acc_ff + prod;
         MAC_SUB:  acc_in = acc_ff - prod;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

// ----- design/fcl_checker.sv -----
// Port-level checks of the FOC current loop, bound to the top level.
// Depends only on the ports of foc_current_loop_core.
module fcl_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_tvalid,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [111:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= 16'd64000 && rsp_tdata[31:16] <= 16'd64000
                     && rsp_tdata[47:32] <= 16'd64000)
      else $error("duty out of range");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind foc_current_loop_core fcl_checker u_fcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
